/* src/cfdm_pkg.sv */
// Shared widths, codes and command and status structs for the capture frequency and duty meter.
// Used by the channel interfaces, the controller, the datapath and the top level.
package cfdm_pkg;

   localparam int STAMP_WIDTH_DEFAULT = 32;

   localparam int STAMP_FIELD_W = 32;
   localparam int CHANNEL_W     = 3;
   localparam int KIND_W        = 2;
   localparam int FREQ_W        = 27;
   localparam int DUTY_PCT_W    = 7;
   localparam int DUTY_HUN_W    = 14;
   localparam int RPM_W         = 32;
   localparam int FACTOR_W      = 8;
   localparam int RPM_PROD_W    = FREQ_W + FACTOR_W;
   localparam int DIV_CNT_W     = $clog2(FREQ_W + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 27;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_CLOCK = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RPM_FACTOR  = 1'b1;

   localparam logic [FREQ_W-1:0]   TIMER_CLOCK_RESET = 27'd24000000;
   localparam logic [FACTOR_W-1:0] RPM_FACTOR_RESET  = 8'd30;

   localparam logic [DUTY_HUN_W-1:0] DUTY_FULL_PCT = 14'd100;
   localparam logic [DUTY_HUN_W-1:0] DUTY_FULL_HUN = 14'd10000;

   localparam logic [KIND_W-1:0] KIND_GENERIC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SPEED   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DUTY    = 2'd2;

   localparam logic [CHANNEL_W-1:0] CHAN_GENERIC = 3'd4;

   typedef struct packed {
      logic capture;
      logic load;
      logic freq_start;
      logic duty_mul;
      logic duty_start;
      logic div_step;
      logic freq_store;
      logic duty_store;
      logic rpm_mul;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic              div_done;
      logic              period_error;
      logic [KIND_W-1:0] kind;
   } status_type;

endpackage

/* src/cfdm_req_if.sv */
// Input channel carrying one capture event per item.
// Depends on cfdm_pkg for the field widths.
interface cfdm_req_if;
   import cfdm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STAMP_FIELD_W-1:0] rise_stamp;
   logic [STAMP_FIELD_W-1:0] fall_stamp;
   logic [CHANNEL_W-1:0]     channel;
   logic                     hold;

   modport source (output valid, output rise_stamp, output fall_stamp, output channel,
                   output hold, input ready);
   modport sink (input valid, input rise_stamp, input fall_stamp, input channel,
                 input hold, output ready);
endinterface

/* src/cfdm_rsp_if.sv */
// Result channel carrying one measurement per item.
// Depends on cfdm_pkg for the field widths.
interface cfdm_rsp_if;
   import cfdm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic                  motor_id;
   logic [FREQ_W-1:0]     frequency_hz;
   logic [DUTY_PCT_W-1:0] duty_percent;
   logic [DUTY_HUN_W-1:0] duty_hundredths;
   logic [RPM_W-1:0]      motor_rpm;
   logic                  period_error;

   modport source (output valid, output kind, output motor_id, output frequency_hz,
                   output duty_percent, output duty_hundredths, output motor_rpm,
                   output period_error, input ready);
   modport sink (input valid, input kind, input motor_id, input frequency_hz,
                 input duty_percent, input duty_hundredths, input motor_rpm,
                 input period_error, output ready);
endinterface

/* src/capture_frequency_duty_meter.sv */
// Top level of the capture frequency and duty meter: controller, datapath and assertions.
// Depends on cfdm_pkg, cfdm_req_if, cfdm_rsp_if, cfdm_ctrl and cfdm_datapath.
//
//   Port       Direction  Contents
//   req_bus    in         rise_stamp, fall_stamp, channel, hold
//   rsp_bus    out        kind, motor_id, frequency_hz, duty_percent, duty_hundredths,
//                         motor_rpm, period_error
//   csr_*      in         write enable, register index, write data
//
// An item that opens a pair, is held, or produces no result leaves the block idle and ready.
// Otherwise a generic item runs frequency division, duty multiply and duty division, a speed
// item frequency division and rpm multiply, a duty item duty multiply and division, a zero
// period none; both divisions use the shared radix-2 divider, one quotient bit per cycle.
// Reset is synchronous and active high; no clearing pass is needed afterward.
// A finished result waits in the output register while the next item is accepted,
// and the block stalls only when a second result is ready before the first is taken.
module capture_frequency_duty_meter #(
   parameter int STAMP_WIDTH = cfdm_pkg::STAMP_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   cfdm_req_if.sink                         req_bus,
   cfdm_rsp_if.source                       rsp_bus,
   input  logic                             csr_write_en,
   input  logic [cfdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cfdm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cfdm_pkg::*;

   cmd_type    cmd;
   status_type status;

   cfdm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_hold    (req_bus.hold),
      .req_channel (req_bus.channel),
      .req_ready   (req_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   cfdm_datapath #(
      .STAMP_WIDTH (STAMP_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rise_stamp      (req_bus.rise_stamp),
      .fall_stamp      (req_bus.fall_stamp),
      .channel         (req_bus.channel),
      .cmd             (cmd),
      .status          (status),
      .kind            (rsp_bus.kind),
      .motor_id        (rsp_bus.motor_id),
      .frequency_hz    (rsp_bus.frequency_hz),
      .duty_percent    (rsp_bus.duty_percent),
      .duty_hundredths (rsp_bus.duty_hundredths),
      .motor_rpm       (rsp_bus.motor_rpm),
      .period_error    (rsp_bus.period_error)
   );

   // A new result must never overwrite one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result register overwritten while occupied");

   // The divider is stepped only while quotient bits remain.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !status.div_done)
      else $error("divider stepped past its last bit");

   // A zero period yields a result with every value field cleared.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.period_error) |->
         (rsp_bus.frequency_hz == '0 && rsp_bus.duty_percent == '0 &&
          rsp_bus.duty_hundredths == '0 && rsp_bus.motor_rpm == '0))
      else $error("period error result carries nonzero values");

   // A completing generic item must occupy the block and make it refuse further input.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && !req_bus.hold && cmd.load &&
       req_bus.channel == CHAN_GENERIC) |=> !req_bus.ready)
      else $error("generic item did not occupy the block");

endmodule

/* src/cfdm_ctrl.sv */
// Controller state machine: pairs capture events, counts motor reports, sequences the divider.
// Depends on cfdm_pkg for command and status structs.
module cfdm_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_hold,
   input  logic [cfdm_pkg::CHANNEL_W-1:0] req_channel,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  cfdm_pkg::status_type         status,
   output cfdm_pkg::cmd_type            cmd
);
   import cfdm_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DISPATCH  = 3'd1;
   localparam logic [2:0] ST_FREQ_DIV  = 3'd2;
   localparam logic [2:0] ST_DUTY_MUL  = 3'd3;
   localparam logic [2:0] ST_DUTY_LOAD = 3'd4;
   localparam logic [2:0] ST_DUTY_DIV  = 3'd5;
   localparam logic [2:0] ST_RPM_MUL   = 3'd6;
   localparam logic [2:0] ST_FINISH    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       pair_open_ff, pair_open_in;
   logic       report_count_ff, report_count_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      pair_open_in    = pair_open_ff;
      report_count_in = report_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      cmd             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_hold) begin
               if (!pair_open_ff) begin
                  cmd.capture  = 1'b1;
                  pair_open_in = 1'b1;
               end else if (req_channel <= CHAN_GENERIC) begin
                  pair_open_in = 1'b0;
                  cmd.load     = 1'b1;
                  if (req_channel == CHAN_GENERIC) begin
                     state_in = ST_DISPATCH;
                  end else begin
                     report_count_in = !report_count_ff;
                     if (report_count_ff) begin
                        state_in = ST_DISPATCH;
                     end
                  end
               end
            end
         end
         ST_DISPATCH: begin
            if (status.period_error) begin
               state_in = ST_FINISH;
            end else if (status.kind == KIND_DUTY) begin
               state_in = ST_DUTY_MUL;
            end else begin
               cmd.freq_start = 1'b1;
               state_in       = ST_FREQ_DIV;
            end
         end
         ST_FREQ_DIV: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.freq_store = 1'b1;
               state_in = (status.kind == KIND_GENERIC) ? ST_DUTY_MUL : ST_RPM_MUL;
            end
         end
         ST_DUTY_MUL: begin
            cmd.duty_mul = 1'b1;
            state_in     = ST_DUTY_LOAD;
         end
         ST_DUTY_LOAD: begin
            cmd.duty_start = 1'b1;
            state_in       = ST_DUTY_DIV;
         end
         ST_DUTY_DIV: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.duty_store = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_RPM_MUL: begin
            cmd.rpm_mul = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pair_open_ff    <= 1'b0;
         report_count_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pair_open_ff    <= pair_open_in;
         report_count_ff <= report_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

endmodule

/* src/cfdm_datapath.sv */
// Datapath: configuration registers, stamp arithmetic, radix-2 divider, multipliers, result register.
// Depends on cfdm_pkg for widths, codes and the command and status structs.
module cfdm_datapath #(
   parameter int STAMP_WIDTH = cfdm_pkg::STAMP_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [cfdm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cfdm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [cfdm_pkg::STAMP_FIELD_W-1:0]  rise_stamp,
   input  logic [cfdm_pkg::STAMP_FIELD_W-1:0]  fall_stamp,
   input  logic [cfdm_pkg::CHANNEL_W-1:0]      channel,
   input  cfdm_pkg::cmd_type                   cmd,
   output cfdm_pkg::status_type                status,
   output logic [cfdm_pkg::KIND_W-1:0]         kind,
   output logic                                motor_id,
   output logic [cfdm_pkg::FREQ_W-1:0]         frequency_hz,
   output logic [cfdm_pkg::DUTY_PCT_W-1:0]     duty_percent,
   output logic [cfdm_pkg::DUTY_HUN_W-1:0]     duty_hundredths,
   output logic [cfdm_pkg::RPM_W-1:0]          motor_rpm,
   output logic                                period_error
);
   import cfdm_pkg::*;

   localparam int SW     = STAMP_WIDTH;
   localparam int PROD_W = SW + DUTY_HUN_W;

   logic [FREQ_W-1:0]   timer_clock_ff;
   logic [FACTOR_W-1:0] rpm_factor_ff;

   logic [SW-1:0]         start_ff;
   logic [SW-1:0]         period_ff;
   logic [SW-1:0]         high_ff;
   logic [KIND_W-1:0]     kind_ff;
   logic                  id_ff;
   logic                  err_ff;
   logic [FREQ_W-1:0]     freq_ff;
   logic [DUTY_PCT_W-1:0] pct_ff;
   logic [DUTY_HUN_W-1:0] hun_ff;
   logic [RPM_W-1:0]      rpm_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  sat_ff;

   logic [SW-1:0]        rem_ff;
   logic [FREQ_W-1:0]    num_ff;
   logic [FREQ_W-1:0]    quot_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   logic [KIND_W-1:0]     out_kind_ff;
   logic                  out_id_ff;
   logic [FREQ_W-1:0]     out_freq_ff;
   logic [DUTY_PCT_W-1:0] out_pct_ff;
   logic [DUTY_HUN_W-1:0] out_hun_ff;
   logic [RPM_W-1:0]      out_rpm_ff;
   logic                  out_err_ff;

   logic [SW-1:0]         rise_in;
   logic [SW-1:0]         period_in;
   logic [KIND_W-1:0]     kind_in;
   logic [DUTY_HUN_W-1:0] duty_full;
   logic [PROD_W-1:0]     prod_in;
   logic [SW:0]           trial;
   logic [SW:0]           diff;
   logic [DUTY_HUN_W-1:0] duty_value;
   logic [RPM_PROD_W-1:0] rpm_prod;

   assign rise_in   = rise_stamp[SW-1:0];
   assign period_in = rise_in - start_ff;

   always_comb begin
      if (channel == CHAN_GENERIC) begin
         kind_in = KIND_GENERIC;
      end else if (channel[0]) begin
         kind_in = KIND_SPEED;
      end else begin
         kind_in = KIND_DUTY;
      end
   end

   assign duty_full  = (kind_ff == KIND_GENERIC) ? DUTY_FULL_PCT : DUTY_FULL_HUN;
   assign prod_in    = PROD_W'(high_ff) * PROD_W'(duty_full);
   assign trial      = {rem_ff, num_ff[FREQ_W-1]};
   assign diff       = trial - {1'b0, period_ff};
   assign duty_value = sat_ff ? duty_full : quot_ff[DUTY_HUN_W-1:0];
   assign rpm_prod   = RPM_PROD_W'(freq_ff) * RPM_PROD_W'(rpm_factor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_clock_ff <= TIMER_CLOCK_RESET;
         rpm_factor_ff  <= RPM_FACTOR_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TIMER_CLOCK: timer_clock_ff <= csr_wdata[FREQ_W-1:0];
            CSR_RPM_FACTOR:  rpm_factor_ff  <= csr_wdata[FACTOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         start_ff <= rise_in;
      end
      if (cmd.load) begin
         period_ff <= period_in;
         high_ff   <= rise_in - fall_stamp[SW-1:0];
         kind_ff   <= kind_in;
         id_ff     <= (kind_in == KIND_GENERIC) ? 1'b0 : channel[1];
         err_ff    <= (period_in == '0);
         freq_ff   <= '0;
         pct_ff    <= '0;
         hun_ff    <= '0;
         rpm_ff    <= '0;
      end
      if (cmd.duty_mul) begin
         prod_ff <= prod_in;
         sat_ff  <= (high_ff >= period_ff);
      end
      if (cmd.freq_start) begin
         rem_ff  <= '0;
         num_ff  <= timer_clock_ff;
         quot_ff <= '0;
         cnt_ff  <= DIV_CNT_W'(FREQ_W);
      end else if (cmd.duty_start) begin
         rem_ff  <= prod_ff[PROD_W-1:DUTY_HUN_W];
         num_ff  <= {prod_ff[DUTY_HUN_W-1:0], {(FREQ_W - DUTY_HUN_W){1'b0}}};
         quot_ff <= '0;
         cnt_ff  <= DIV_CNT_W'(DUTY_HUN_W);
      end else if (cmd.div_step) begin
         rem_ff  <= diff[SW] ? trial[SW-1:0] : diff[SW-1:0];
         num_ff  <= {num_ff[FREQ_W-2:0], 1'b0};
         quot_ff <= {quot_ff[FREQ_W-2:0], !diff[SW]};
         cnt_ff  <= cnt_ff - 1'b1;
      end
      if (cmd.freq_store) begin
         freq_ff <= quot_ff;
      end
      if (cmd.duty_store) begin
         if (kind_ff == KIND_GENERIC) begin
            pct_ff <= duty_value[DUTY_PCT_W-1:0];
         end else begin
            hun_ff <= duty_value;
         end
      end
      if (cmd.rpm_mul) begin
         rpm_ff <= (|rpm_prod[RPM_PROD_W-1:RPM_W]) ? '1 : rpm_prod[RPM_W-1:0];
      end
      if (cmd.out_load) begin
         out_kind_ff <= kind_ff;
         out_id_ff   <= id_ff;
         out_freq_ff <= freq_ff;
         out_pct_ff  <= pct_ff;
         out_hun_ff  <= hun_ff;
         out_rpm_ff  <= rpm_ff;
         out_err_ff  <= err_ff;
      end
   end

   assign status.div_done     = (cnt_ff == '0);
   assign status.period_error = err_ff;
   assign status.kind         = kind_ff;

   assign kind            = out_kind_ff;
   assign motor_id        = out_id_ff;
   assign frequency_hz    = out_freq_ff;
   assign duty_percent    = out_pct_ff;
   assign duty_hundredths = out_hun_ff;
   assign motor_rpm       = out_rpm_ff;
   assign period_error    = out_err_ff;

endmodule

/* verif/capture_frequency_duty_meter_tb.sv */
// Testbench for capture_frequency_duty_meter: drives capture events, predicts every
// measurement in a behavioral model of its own and checks each result field by field.
// Depends on cfdm_pkg, cfdm_req_if, cfdm_rsp_if and the capture_frequency_duty_meter RTL.
module capture_frequency_duty_meter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfdm_pkg::*;

   localparam logic [CHANNEL_W-1:0] CHAN_DUTY_0  = 3'd0;
   localparam logic [CHANNEL_W-1:0] CHAN_SPEED_0 = 3'd1;
   localparam logic [CHANNEL_W-1:0] CHAN_DUTY_1  = 3'd2;
   localparam logic [CHANNEL_W-1:0] CHAN_SPEED_1 = 3'd3;
   localparam logic [CHANNEL_W-1:0] CHAN_IDLE_5  = 3'd5;
   localparam logic [CHANNEL_W-1:0] CHAN_IDLE_6  = 3'd6;
   localparam logic [CHANNEL_W-1:0] CHAN_IDLE_7  = 3'd7;

   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTED   = 10;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic                  motor_id;
      logic [FREQ_W-1:0]     frequency_hz;
      logic [DUTY_PCT_W-1:0] duty_percent;
      logic [DUTY_HUN_W-1:0] duty_hundredths;
      logic [RPM_W-1:0]      motor_rpm;
      logic                  period_error;
   } measurement_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cfdm_req_if req_chan ();
   cfdm_rsp_if rsp_chan ();

   capture_frequency_duty_meter dut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_chan),
      .rsp_bus      (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Behavioral copy of the meter state and registers.
   logic [FREQ_W-1:0]        timer_clock_hz = TIMER_CLOCK_RESET;
   logic [FACTOR_W-1:0]      rpm_factor     = RPM_FACTOR_RESET;
   logic                     pair_open      = 1'b0;
   logic [STAMP_FIELD_W-1:0] start_stamp    = '0;
   logic                     motor_phase    = 1'b0;

   measurement_type expected_measurements[$];

   bit          gaps_on       = 1'b1;
   bit          stalls_on     = 1'b1;
   int          stall_left    = 0;
   int          idle_cycles   = 0;
   int unsigned events_sent   = 0;
   int unsigned events_useful = 0;
   int unsigned results_seen  = 0;
   int unsigned settings_used = 1;
   int unsigned failures      = 0;
   int unsigned reported      = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [DUTY_HUN_W-1:0] scale_duty(input logic [31:0] high_time,
                                                        input logic [31:0] period,
                                                        input logic [DUTY_HUN_W-1:0] full);
      logic [63:0] ratio;
      ratio = (64'(high_time) * 64'(full)) / 64'(period);
      return (ratio > 64'(full)) ? full : ratio[DUTY_HUN_W-1:0];
   endfunction

   function automatic string describe(input measurement_type meas);
      return $sformatf("kind=%0d id=%0d freq=%0d pct=%0d hun=%0d rpm=%0d err=%0d",
                       meas.kind, meas.motor_id, meas.frequency_hz, meas.duty_percent,
                       meas.duty_hundredths, meas.motor_rpm, meas.period_error);
   endfunction

   function automatic void predict_capture(input logic [STAMP_FIELD_W-1:0] rise,
                                           input logic [STAMP_FIELD_W-1:0] fall,
                                           input logic [CHANNEL_W-1:0] chan,
                                           input logic hld);
      logic [STAMP_FIELD_W-1:0] period;
      logic [STAMP_FIELD_W-1:0] high_time;
      logic [63:0]              rpm_full;
      measurement_type          meas;
      if (hld)
         return;
      if (!pair_open) begin
         start_stamp = rise;
         pair_open = 1'b1;
         return;
      end
      if (chan > CHAN_GENERIC)
         return;
      pair_open = 1'b0;
      period = rise - start_stamp;
      high_time = rise - fall;
      meas = '0;
      meas.period_error = (period == 0);
      if (chan == CHAN_GENERIC) begin
         meas.kind = KIND_GENERIC;
         if (!meas.period_error) begin
            meas.frequency_hz = FREQ_W'(32'(timer_clock_hz) / period);
            meas.duty_percent = DUTY_PCT_W'(scale_duty(high_time, period, DUTY_FULL_PCT));
         end
      end else begin
         motor_phase = ~motor_phase;
         if (motor_phase)
            return;
         meas.motor_id = chan[1];
         if (chan[0]) begin
            meas.kind = KIND_SPEED;
            if (!meas.period_error) begin
               meas.frequency_hz = FREQ_W'(32'(timer_clock_hz) / period);
               rpm_full = 64'(meas.frequency_hz) * 64'(rpm_factor);
               meas.motor_rpm = (rpm_full > 64'hFFFF_FFFF) ? '1 : rpm_full[RPM_W-1:0];
            end
         end else begin
            meas.kind = KIND_DUTY;
            if (!meas.period_error)
               meas.duty_hundredths = scale_duty(high_time, period, DUTY_FULL_HUN);
         end
      end
      expected_measurements.push_back(meas);
   endfunction

   task automatic send_capture(input logic [STAMP_FIELD_W-1:0] rise,
                               input logic [STAMP_FIELD_W-1:0] fall,
                               input logic [CHANNEL_W-1:0] chan,
                               input logic hld);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.rise_stamp <= rise;
      req_chan.fall_stamp <= fall;
      req_chan.channel    <= chan;
      req_chan.hold       <= hld;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predict_capture(rise, fall, chan, hld);
      events_sent++;
   endtask

   task automatic drain_block();
      req_chan.valid <= 1'b0;
      while (expected_measurements.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      if (index == CSR_TIMER_CLOCK)
         timer_clock_hz = data;
      else
         rpm_factor = data[FACTOR_W-1:0];
   endtask

   task automatic apply_setting(input logic [FREQ_W-1:0] clock_hz,
                                input logic [FACTOR_W-1:0] factor);
      drain_block();
      write_register(CSR_TIMER_CLOCK, clock_hz);
      write_register(CSR_RPM_FACTOR, {(CSR_DATA_W - FACTOR_W)'($urandom), factor});
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [31:0] pick_period();
      case ($urandom_range(0, 19))
         0:       return '0;
         1, 2, 3: return $urandom_range(1, 64);
         4, 5, 6, 7, 8, 9: return $urandom_range(65, 32'h1_0000);
         10, 11, 12, 13: return $urandom_range(32'h1_0000, 32'h100_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_high_time(input logic [31:0] period);
      if ($urandom_range(0, 7) == 0)
         return $urandom;
      return $urandom_range(0, period);
   endfunction

   // Mostly complete pairs with random content; the rest is held, unused-channel or stray items.
   task automatic send_random_capture();
      int unsigned              pick;
      logic [STAMP_FIELD_W-1:0] rise;
      logic [STAMP_FIELD_W-1:0] fall;
      logic [CHANNEL_W-1:0]     chan;
      logic                     hld;
      pick = $urandom_range(0, 99);
      hld = (pick < 4);
      chan = CHANNEL_W'($urandom_range(0, 4));
      if (pick >= 4 && pick < 10)
         chan = CHANNEL_W'($urandom_range(5, 7));
      rise = $urandom;
      fall = $urandom;
      if (pair_open && pick >= 10 && pick < 95) begin
         rise = start_stamp + pick_period();
         fall = rise - pick_high_time(rise - start_stamp);
      end
      if (!hld && (!pair_open || chan <= CHAN_GENERIC))
         events_useful++;
      send_capture(rise, fall, chan, hld);
   endtask

   task automatic run_random_captures(input int unsigned count);
      int unsigned goal;
      goal = events_useful + count;
      while (events_useful < goal)
         send_random_capture();
   endtask

   task automatic test_directed_cases();
      send_capture(32'd100, 32'd0, CHAN_GENERIC, 1'b1);
      send_capture(32'd1000, 32'd0, CHAN_GENERIC, 1'b0);
      send_capture(32'd5000, 32'd4000, CHAN_IDLE_5, 1'b0);
      send_capture(32'd6000, 32'd4000, CHAN_IDLE_6, 1'b0);
      send_capture(32'd7000, 32'd4000, CHAN_IDLE_7, 1'b0);
      send_capture(32'd9000, 32'd4000, CHAN_GENERIC, 1'b1);
      send_capture(32'd25000, 32'd13000, CHAN_GENERIC, 1'b0);
      send_capture(32'hFFFF_FFF0, 32'd0, CHAN_IDLE_7, 1'b0);
      send_capture(32'h10, 32'h11, CHAN_GENERIC, 1'b0);
      send_capture(32'd500, 32'd0, CHAN_GENERIC, 1'b0);
      send_capture(32'd500, 32'd200, CHAN_GENERIC, 1'b0);
      send_capture(32'd0, 32'd0, CHAN_SPEED_0, 1'b0);
      send_capture(32'd48000, 32'd24000, CHAN_SPEED_0, 1'b0);
      send_capture(32'd0, 32'd0, CHAN_SPEED_1, 1'b0);
      send_capture(32'd1, 32'd0, CHAN_SPEED_1, 1'b0);
      send_capture(32'd0, 32'd0, CHAN_DUTY_0, 1'b0);
      send_capture(32'd10000, 32'd7500, CHAN_DUTY_0, 1'b0);
      send_capture(32'd0, 32'd0, CHAN_DUTY_1, 1'b0);
      send_capture(32'd10000, 32'd7500, CHAN_DUTY_1, 1'b0);
      send_capture(32'd0, 32'd0, CHAN_SPEED_0, 1'b0);
      send_capture(32'd0, 32'd0, CHAN_SPEED_0, 1'b0);
      send_capture(32'd0, 32'd0, CHAN_DUTY_0, 1'b0);
      send_capture(32'd0, 32'd0, CHAN_DUTY_0, 1'b0);
      send_capture(32'hFFFF_FFFF, 32'hFFFF_FFFF, CHAN_GENERIC, 1'b0);
      send_capture(32'hFFFF_FFFE, 32'd0, CHAN_GENERIC, 1'b0);
      send_capture(32'hFFFF_FFFF, 32'hFFFF_FFFF, CHAN_IDLE_7, 1'b1);
   endtask

   task automatic test_register_extremes();
      apply_setting(27'd100000000, 8'd255);
      run_random_captures(25);
      apply_setting(27'd1, 8'd1);
      run_random_captures(25);
      apply_setting(27'd0, 8'd128);
      run_random_captures(20);
      apply_setting('1, 8'd255);
      run_random_captures(25);
      apply_setting(27'd24000000, 8'd0);
      run_random_captures(20);
      apply_setting(27'd100000000, 8'd1);
      run_random_captures(25);
   endtask

   task automatic test_random_traffic();
      repeat (6) begin
         apply_setting(FREQ_W'($urandom_range(1, 100000000)), FACTOR_W'($urandom_range(1, 255)));
         run_random_captures(200);
      end
   endtask

   task automatic test_back_to_back();
      apply_setting(FREQ_W'($urandom_range(1, 100000000)), FACTOR_W'($urandom_range(1, 255)));
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      run_random_captures(150);
   endtask

   always @(posedge clock) begin
      if (reset || !stalls_on) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      measurement_type got;
      measurement_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.kind            = rsp_chan.kind;
         got.motor_id        = rsp_chan.motor_id;
         got.frequency_hz    = rsp_chan.frequency_hz;
         got.duty_percent    = rsp_chan.duty_percent;
         got.duty_hundredths = rsp_chan.duty_hundredths;
         got.motor_rpm       = rsp_chan.motor_rpm;
         got.period_error    = rsp_chan.period_error;
         results_seen++;
         if (expected_measurements.size() == 0) begin
            failures++;
            if (reported < MAX_REPORTED) begin
               reported++;
               $display("%0t: unexpected measurement %s", $realtime, describe(got));
            end
         end else begin
            want = expected_measurements.pop_front();
            if (got.kind !== want.kind || got.motor_id !== want.motor_id ||
                got.frequency_hz !== want.frequency_hz ||
                got.duty_percent !== want.duty_percent ||
                got.duty_hundredths !== want.duty_hundredths ||
                got.motor_rpm !== want.motor_rpm ||
                got.period_error !== want.period_error) begin
               failures++;
               if (reported < MAX_REPORTED) begin
                  reported++;
                  $display("%0t: mismatch expected %s", $realtime, describe(want));
                  $display("%0t:          actual   %s", $realtime, describe(got));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d cycles without progress.", idle_cycles);
         $display("FAIL capture_frequency_duty_meter");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.rise_stamp <= '0;
      req_chan.fall_stamp <= '0;
      req_chan.channel    <= '0;
      req_chan.hold       <= 1'b0;
      csr_write_en        <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_register_extremes();
      test_random_traffic();
      test_back_to_back();
      drain_block();
      failures += expected_measurements.size();
      $display("Sent %0d capture events (%0d counted) under %0d register settings.",
               events_sent, events_useful, settings_used);
      $display("Checked %0d measurements, %0d failures.", results_seen, failures);
      if (failures == 0)
         $display("PASS capture_frequency_duty_meter");
      else
         $display("FAIL capture_frequency_duty_meter");
      $finish;
   end

endmodule
